// ===== hdl/imu_sfp_pkg.sv =====
// Shared constants, codes and the result word type for the IMU serial frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package imu_sfp_pkg;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_GYRO  = 8'h52;
  localparam logic [7:0] TYPE_QUAT  = 8'h59;

  // bytes 0..9 are summed, byte 10 carries the checksum
  localparam logic [3:0] SUM_LEN = 4'd10;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_BODY = 2'd2;

  localparam logic [1:0] KIND_ANGLE = 2'd0;
  localparam logic [1:0] KIND_ACCEL = 2'd1;
  localparam logic [1:0] KIND_GYRO  = 2'd2;
  localparam logic [1:0] KIND_QUAT  = 2'd3;

  typedef struct packed {
    logic        [1:0]  kind;
    logic signed [15:0] val_a;
    logic signed [15:0] val_b;
    logic signed [15:0] val_c;
    logic signed [15:0] val_d;
  } frame_res_t;

endpackage

`default_nettype wire

// ===== hdl/imu_serial_frame_parser.sv =====
// Top level of the IMU serial frame parser: byte input register, parser, result register.
// Depends on imu_sfp_pkg and imu_sfp_parse.
`default_nettype none

// Takes one received serial byte per word on the rx channel and finds 11-byte
// sensor frames (0x55 header, type byte, eight payload bytes, 8-bit sum). Each
// good frame yields one word on the res channel: its kind and four signed
// little-endian raw counts; value_d is zero except for quaternion frames. Frames
// with a bad checksum give nothing. The block takes one byte every cycle while
// rx_stall is low; a frame's checksum byte is taken into the byte register, which
// feeds the parser, whose result goes straight into the result register.
// rx_stall rises only while a byte is held in the byte register and a result
// waits in the result register under res_stall.

module imu_serial_frame_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  output logic                    rx_stall,
  input  wire logic [7:0]         rx_byte,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic [1:0]              frame_kind,
  output logic signed [15:0]      value_a,
  output logic signed [15:0]      value_b,
  output logic signed [15:0]      value_c,
  output logic signed [15:0]      value_d
);
  import imu_sfp_pkg::*;

  logic       in_vld;
  logic [7:0] in_byte;
  logic       proc_ok;
  logic       fire;
  logic       hit;
  frame_res_t res;

  assign proc_ok  = !res_valid || !res_stall;
  assign fire     = in_vld && proc_ok;
  assign rx_stall = in_vld && !proc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!rx_stall) begin
      in_vld <= rx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  imu_sfp_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_byte),
    .hit     (hit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (proc_ok) begin
      res_valid <= fire && hit;
    end
  end

  // hold the result while it is stalled
  always_ff @(posedge clk) begin
    if (fire && hit) begin
      frame_kind <= res.kind;
      value_a    <= res.val_a;
      value_b    <= res.val_b;
      value_c    <= res.val_c;
      value_d    <= res.val_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/imu_sfp_parse.sv =====
// Frame parser state: phase, byte position, running checksum and payload bytes.
// Depends on imu_sfp_pkg. Advances by one byte on each cycle that fire is high.
`default_nettype none

module imu_sfp_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic [7:0]         byte_in,
  output logic                    hit,
  output imu_sfp_pkg::frame_res_t res
);
  import imu_sfp_pkg::*;

  logic [1:0] phase, phase_next;
  logic [3:0] pos, pos_next;
  logic [1:0] kind, kind_next;
  logic [7:0] sum, sum_next;
  logic [7:0] store [8];
  logic       store_we;
  logic [2:0] store_idx;
  logic       type_ok;
  logic [1:0] type_kind;

  always_comb begin
    type_ok   = 1'b1;
    type_kind = KIND_ANGLE;
    case (byte_in)
      TYPE_ANGLE: type_kind = KIND_ANGLE;
      TYPE_ACCEL: type_kind = KIND_ACCEL;
      TYPE_GYRO:  type_kind = KIND_GYRO;
      TYPE_QUAT:  type_kind = KIND_QUAT;
      default:    type_ok   = 1'b0;
    endcase
  end

  assign store_idx = 3'(pos[2:0] - 3'd2);

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    kind_next  = kind;
    sum_next   = sum;
    store_we   = 1'b0;
    hit        = 1'b0;
    case (phase)
      PH_TYPE: begin
        if (type_ok) begin
          phase_next = PH_BODY;
          pos_next   = 4'd2;
          kind_next  = type_kind;
          sum_next   = 8'(sum + byte_in);
        end else if (byte_in == HDR_BYTE) begin
          // unknown type byte that is itself a header: restart on it
          phase_next = PH_TYPE;
          pos_next   = 4'd1;
          kind_next  = KIND_ANGLE;
          sum_next   = HDR_BYTE;
        end else begin
          phase_next = PH_IDLE;
          pos_next   = 4'd0;
          kind_next  = KIND_ANGLE;
          sum_next   = 8'd0;
        end
      end
      PH_BODY: begin
        if (pos < SUM_LEN) begin
          store_we = 1'b1;
          sum_next = 8'(sum + byte_in);
          pos_next = 4'(pos + 4'd1);
        end else begin
          // checksum byte: emit on match, drop otherwise
          hit        = (byte_in == sum);
          phase_next = PH_IDLE;
          pos_next   = 4'd0;
          kind_next  = KIND_ANGLE;
          sum_next   = 8'd0;
        end
      end
      default: begin
        // idle, and the unused phase code
        if (byte_in == HDR_BYTE) begin
          phase_next = PH_TYPE;
          pos_next   = 4'd1;
          sum_next   = HDR_BYTE;
        end else begin
          phase_next = PH_IDLE;
          pos_next   = 4'd0;
          sum_next   = 8'd0;
        end
        kind_next = KIND_ANGLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      pos   <= 4'd0;
      kind  <= KIND_ANGLE;
      sum   <= 8'd0;
    end else if (fire) begin
      phase <= phase_next;
      pos   <= pos_next;
      kind  <= kind_next;
      sum   <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      store[store_idx] <= byte_in;
    end
  end

  always_comb begin
    res.kind  = kind;
    res.val_a = {store[1], store[0]};
    res.val_b = {store[3], store[2]};
    res.val_c = {store[5], store[4]};
    res.val_d = (kind == KIND_QUAT) ? {store[7], store[6]} : 16'sd0;
  end

endmodule

`default_nettype wire

// ===== hdl/imu_sfp_check.sv =====
// Port-level checker for imu_serial_frame_parser, bound to the top level.
// Depends on imu_sfp_pkg.
`default_nettype none

module imu_sfp_check (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              rx_stall,
  input wire logic              res_valid,
  input wire logic              res_stall,
  input wire logic [1:0]        frame_kind,
  input wire logic signed [15:0] value_a,
  input wire logic signed [15:0] value_d
);
  import imu_sfp_pkg::*;

  a_reset_clear: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(frame_kind) && $stable(value_a)
      && $stable(value_d))
    else $error("stalled result word changed");

  a_vald_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (frame_kind != KIND_QUAT) |-> value_d == 16'sd0)
    else $error("value_d nonzero outside quaternion frame");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !rx_stall)
    else $error("input stalled with empty result register");

endmodule

bind imu_serial_frame_parser imu_sfp_check u_check (
  .clk        (clk),
  .rst        (rst),
  .rx_stall   (rx_stall),
  .res_valid  (res_valid),
  .res_stall  (res_stall),
  .frame_kind (frame_kind),
  .value_a    (value_a),
  .value_d    (value_d)
);

`default_nettype wire

// ===== tb/imu_sfp_checker.sv =====
// Checker for the IMU serial frame parser: watches the byte and result channels,
// predicts each good frame and compares it field by field. Depends on imu_sfp_pkg.
module imu_sfp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  input  logic               rx_stall,
  input  logic [7:0]         rx_byte,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic [1:0]         frame_kind,
  input  logic signed [15:0] value_a,
  input  logic signed [15:0] value_b,
  input  logic signed [15:0] value_c,
  input  logic signed [15:0] value_d,
  output int                 fail_count,
  output int                 outstanding,
  output int                 frames_checked
);
  import imu_sfp_pkg::*;

  logic [1:0] fr_phase;
  logic [3:0] fr_pos;
  logic [1:0] fr_kind;
  logic [7:0] fr_sum;
  logic [7:0] body_bytes [8];
  frame_res_t expected_frames [$];

  initial begin
    fail_count = 0;
    outstanding = 0;
    frames_checked = 0;
  end

  // drop the frame in progress; a header byte opens a new one
  task automatic restart_on(input logic [7:0] b);
    fr_kind = KIND_ANGLE;
    if (b == HDR_BYTE) begin
      fr_phase = PH_TYPE;
      fr_pos = 4'd1;
      fr_sum = HDR_BYTE;
    end else begin
      fr_phase = PH_IDLE;
      fr_pos = 4'd0;
      fr_sum = 8'd0;
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [1:0] k;
    bit known;
    frame_res_t fr;
    case (fr_phase)
      PH_TYPE: begin
        known = 1'b1;
        k = KIND_ANGLE;
        case (b)
          TYPE_ANGLE: k = KIND_ANGLE;
          TYPE_ACCEL: k = KIND_ACCEL;
          TYPE_GYRO:  k = KIND_GYRO;
          TYPE_QUAT:  k = KIND_QUAT;
          default:    known = 1'b0;
        endcase
        if (known) begin
          fr_kind = k;
          fr_phase = PH_BODY;
          fr_pos = 4'd2;
          fr_sum = fr_sum + b;
        end else begin
          // re-examine the rejected type byte as a header
          restart_on(b);
        end
      end
      PH_BODY: begin
        if (fr_pos < SUM_LEN) begin
          body_bytes[3'(fr_pos - 4'd2)] = b;
          fr_sum = fr_sum + b;
          fr_pos = fr_pos + 4'd1;
        end else begin
          if (b == fr_sum) begin
            fr.kind  = fr_kind;
            fr.val_a = {body_bytes[1], body_bytes[0]};
            fr.val_b = {body_bytes[3], body_bytes[2]};
            fr.val_c = {body_bytes[5], body_bytes[4]};
            fr.val_d = (fr_kind == KIND_QUAT) ? {body_bytes[7], body_bytes[6]} : 16'sd0;
            expected_frames.push_back(fr);
          end
          fr_phase = PH_IDLE;
          fr_pos = 4'd0;
          fr_sum = 8'd0;
          fr_kind = KIND_ANGLE;
        end
      end
      default: restart_on(b);
    endcase
  endtask

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    frame_res_t want;
    if (rst) begin
      fr_phase = PH_IDLE;
      fr_pos = 4'd0;
      fr_sum = 8'd0;
      fr_kind = KIND_ANGLE;
      expected_frames.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_frames.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d a %h b %h c %h d %h",
                   $time, frame_kind, value_a, value_b, value_c, value_d);
          fail_count++;
        end else begin
          want = expected_frames.pop_front();
          check_field("frame_kind", 16'(want.kind), 16'(frame_kind));
          check_field("value_a", want.val_a, value_a);
          check_field("value_b", want.val_b, value_b);
          check_field("value_c", want.val_c, value_c);
          check_field("value_d", want.val_d, value_d);
          frames_checked++;
        end
      end
      if (rx_valid && !rx_stall)
        absorb_byte(rx_byte);
    end
    outstanding = expected_frames.size();
  end

endmodule

// ===== tb/imu_serial_frame_parser_test.sv =====
// Top of the IMU serial frame parser testbench: clock, reset, byte stimulus and
// result-side stalls. Depends on imu_sfp_pkg, imu_sfp_checker and the block.
module imu_serial_frame_parser_test;
  import imu_sfp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              rx_valid = 1'b0;
  logic              rx_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              res_valid;
  logic              res_stall = 1'b0;
  logic [1:0]        frame_kind;
  logic signed [15:0] value_a, value_b, value_c, value_d;

  int fail_count, outstanding, frames_checked;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_request = 1'b0;
  bit hold_seen = 1'b0;
  int hold_left = 0;

  imu_serial_frame_parser DUT (
    .clk, .rst, .rx_valid, .rx_stall, .rx_byte,
    .res_valid, .res_stall, .frame_kind, .value_a, .value_b, .value_c, .value_d
  );

  imu_sfp_checker checker_i (
    .clk, .rst, .rx_valid, .rx_stall, .rx_byte,
    .res_valid, .res_stall, .frame_kind, .value_a, .value_b, .value_c, .value_d,
    .fail_count, .outstanding, .frames_checked
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random stalls, or a long hold when one is requested
  always @(negedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = LONG_HOLD - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid <= 1'b0;
      @(negedge clk);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  // header, type, body bytes low first, then the sum (spoiled on request)
  task automatic send_frame(input logic [7:0] tbyte, input logic [63:0] body,
                            input bit spoil);
    logic [7:0] sum;
    sum = HDR_BYTE + tbyte;
    send_byte(HDR_BYTE);
    send_byte(tbyte);
    for (int i = 0; i < 8; i++) begin
      sum = sum + body[8*i +: 8];
      send_byte(body[8*i +: 8]);
    end
    if (spoil) sum = sum + 8'($urandom_range(1, 255));
    send_byte(sum);
  endtask

  function automatic logic [7:0] type_of(input logic [1:0] k);
    case (k)
      KIND_ANGLE: return TYPE_ANGLE;
      KIND_ACCEL: return TYPE_ACCEL;
      KIND_GYRO:  return TYPE_GYRO;
      default:    return TYPE_QUAT;
    endcase
  endfunction

  // lean toward sign extremes and header bytes inside the body
  function automatic logic [63:0] random_body();
    logic [63:0] body;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(7))
        0: body[8*i +: 8] = 8'h00;
        1: body[8*i +: 8] = 8'hFF;
        2: body[8*i +: 8] = 8'h80;
        3: body[8*i +: 8] = 8'h7F;
        4: body[8*i +: 8] = HDR_BYTE;
        default: body[8*i +: 8] = 8'($urandom_range(255));
      endcase
    end
    return body;
  endfunction

  task automatic random_chunk();
    int sel, n;
    sel = $urandom_range(99);
    if (sel < 70) begin
      send_frame(type_of(2'($urandom_range(3))), random_body(), $urandom_range(99) < 12);
    end else if (sel < 80) begin
      send_byte(HDR_BYTE);
      send_byte(8'($urandom_range(255)));
    end else if (sel < 88) begin
      // cut-off frame; the bytes that follow land in its body
      send_byte(HDR_BYTE);
      send_byte(type_of(2'($urandom_range(3))));
      n = $urandom_range(7);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    end else begin
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle_pct = 11;
    recv_stall_pct = 63;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(TYPE_ANGLE, 64'h0, 1'b0);
    send_frame(TYPE_ACCEL, {8{8'hFF}}, 1'b0);
    send_frame(TYPE_GYRO, 64'h7FFF_8000_5555_0055, 1'b0);
    // a second header in the type slot starts the frame over
    send_byte(HDR_BYTE);
    send_frame(TYPE_QUAT, random_body(), 1'b0);
    send_byte(HDR_BYTE);
    send_byte(8'h50);
    send_frame(TYPE_QUAT, 64'h8000_7FFF_0001_FFFE, 1'b1);
    send_frame(TYPE_QUAT, 64'h8000_7FFF_0001_FFFE, 1'b0);

    while (bytes_sent < 560) random_chunk();

    // hold the sender until every frame has drained
    rx_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    send_idle_pct = 63;
    recv_stall_pct = 11;
    while (bytes_sent < 1040) random_chunk();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request <= ~hold_request;
    for (int i = 0; i < 8; i++)
      send_frame(type_of(2'($urandom_range(3))), random_body(), 1'b0);
    while (bytes_sent < 1450) random_chunk();
    rx_valid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d bytes covering all frame kinds, bad sums, rejected type bytes", bytes_sent);
    $display("and cut-off frames; %0d frames compared under mixed and long stalls.",
             frames_checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/imu_sfp_pkg.sv
hdl/imu_sfp_parse.sv
hdl/imu_serial_frame_parser.sv
hdl/imu_sfp_check.sv
tb/imu_sfp_checker.sv
tb/imu_serial_frame_parser_test.sv
